// File: sv/q8bd_pkg.sv
// shared types and constants for the q8_0 / bf16 weight dequantizer
package q8bd_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned VAL_W  = 16;

  localparam logic FMT_BF16 = 1'b0;
  localparam logic FMT_Q8_0 = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_TRUNC = 1'b1;

  // work kinds passed from front to back
  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,
    KIND_QUANT = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // one queued job
  typedef struct packed {
    kind_t       kind;
    logic [15:0] scale;
    logic [15:0] raw;
    logic        last;
  } job_t;

  // result item
  typedef struct packed {
    logic [15:0] value;
    logic        last;
    logic        status;
  } res_t;

endpackage

// File: sv/q8bd_front.sv
// front end: tracks block position, gathers scale and pairs, emits jobs
module q8bd_front
  import q8bd_pkg::*;
#(
  parameter int unsigned BLOCK_VALUES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fmt,
  input  logic       cfg_wr,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);

  localparam int unsigned BLK_BYTES = BLOCK_VALUES + 2;
  localparam int unsigned POS_W = $clog2(BLK_BYTES);

  logic [POS_W-1:0] pos;
  logic [15:0]      scale;
  logic [7:0]       low_byte;
  logic             take;
  logic             have;
  logic             complete;
  job_t             job_next;

  assign in_ready = job_ready;
  assign take     = in_valid && in_ready;

  // classify the incoming byte
  always_comb begin
    have     = 1'b0;
    complete = 1'b0;
    job_next.kind  = KIND_PASS;
    job_next.scale = scale;
    job_next.raw   = {data_byte, low_byte};
    job_next.last  = last_byte;
    if (fmt == FMT_Q8_0) begin
      if (pos >= POS_W'(2)) begin
        have = 1'b1;
        job_next.kind = KIND_QUANT;
        complete = (pos == POS_W'(BLK_BYTES - 1));
      end
    end else if (pos != '0) begin
      have = 1'b1;
      complete = 1'b1;
    end
    if (last_byte && !complete) begin
      have = 1'b1;
      job_next.kind = KIND_ERROR;
    end
  end

  // position and scale tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cfg_wr) begin
      pos <= '0;
    end else if (take) begin
      if (complete || last_byte) begin
        pos <= '0;
      end else begin
        pos <= pos + POS_W'(1);
      end
      if (fmt == FMT_Q8_0 && pos == '0) begin
        scale[7:0] <= data_byte;
      end
      if (fmt == FMT_Q8_0 && pos == POS_W'(1)) begin
        scale[15:8] <= data_byte;
      end
      if (fmt == FMT_BF16 && pos == '0) begin
        low_byte <= data_byte;
      end
    end
  end

  // output register toward the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (job_ready) begin
      job_valid <= take && have;
      job       <= job_next;
    end
  end

endmodule

// File: sv/q8bd_fifo.sv
// small job queue between front and back
module q8bd_fifo
  import q8bd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  job_t       mem [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  logic       push;
  logic       pop;

  assign wr_ready = (cnt < 3'd3);
  assign rd_valid = (cnt != 3'd0);
  assign rd_data  = mem[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointers and storage
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 2'd1;
      end
      if (pop) begin
        rp <= rp + 2'd1;
      end
      cnt <= cnt + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_data;
    end
  end

endmodule

// File: sv/q8bd_back.sv
// back end: pass, or scale times quant, normalize, round to bf16; output register
module q8bd_back
  import q8bd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  // stage 1 registers: product and class
  logic        s1_valid;
  kind_t       s1_kind;
  logic [15:0] s1_raw;
  logic        s1_last;
  logic        s1_sign;
  logic [17:0] s1_p;
  logic signed [6:0] s1_e;
  logic        s1_special;
  logic [15:0] s1_special_val;

  logic        stall;
  logic        adv1;

  // stage 1 combinational
  logic        hs;
  logic [4:0]  ex;
  logic [9:0]  mant;
  logic        qs;
  logic [7:0]  qb;
  logic [7:0]  qmag;
  logic [10:0] sig_in;
  logic signed [6:0] e_in;
  logic        spec;
  logic [15:0] spec_val;

  always_comb begin
    hs   = job.scale[15];
    ex   = job.scale[14:10];
    mant = job.scale[9:0];
    qb   = job.raw[15:8];
    qs   = qb[7];
    qmag = qs ? (8'd0 - qb) : qb;
    if (ex == 5'h1f) begin
      spec = 1'b1;
      if (mant != '0) begin
        spec_val = {hs, 8'hff, mant[9:3]} | 16'h0040;
      end else if (qmag == 8'd0) begin
        spec_val = 16'h7fc0;
      end else begin
        spec_val = {hs ^ qs, 15'h7f80};
      end
    end else begin
      spec     = 1'b0;
      spec_val = '0;
    end
    if (ex == 5'd0) begin
      sig_in = {1'b0, mant};
      e_in   = -7'sd24;
    end else begin
      sig_in = {1'b1, mant};
      e_in   = 7'($signed({2'b00, ex})) - 7'sd25;
    end
  end

  assign stall     = res_valid && !res_ready;
  assign job_ready = !stall;
  assign adv1      = !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_kind        <= job.kind;
      s1_raw         <= job.raw;
      s1_last        <= job.last;
      s1_sign        <= hs ^ qs;
      s1_p           <= 18'(sig_in) * 18'(qmag);
      s1_e           <= e_in;
      s1_special     <= spec;
      s1_special_val <= spec_val;
    end
  end

  // stage 2: leading one, round, pack
  logic [4:0]  k;
  logic [17:0] pn;
  logic [8:0]  sig8;
  logic [4:0]  kk;
  logic        gbit;
  logic        sticky;
  logic [7:0]  uexp;
  logic [15:0] qval;
  res_t        res_next;

  always_comb begin
    k = 5'd0;
    for (int i = 0; i < 18; i++) begin
      if (s1_p[i]) begin
        k = 5'(i);
      end
    end
    // align leading one to bit 17
    pn     = s1_p << (5'd17 - k);
    sig8   = {1'b0, pn[17:10]};
    gbit   = pn[9];
    sticky = (pn[8:0] != '0);
    if (gbit && (sticky || sig8[0])) begin
      sig8 = sig8 + 9'd1;
    end
    kk = k;
    if (sig8[8]) begin
      sig8 = 9'd128;
      kk   = k + 5'd1;
    end
    // biased exponent, modulo 256
    uexp = 8'(s1_e) + {3'b000, kk} + 8'd127;
    if (s1_special) begin
      qval = s1_special_val;
    end else if (s1_p == '0) begin
      qval = {s1_sign, 15'd0};
    end else begin
      qval = {s1_sign, uexp, sig8[6:0]};
    end
    res_next.last   = s1_last;
    res_next.status = STATUS_OK;
    case (s1_kind)
      KIND_PASS:  res_next.value = s1_raw;
      KIND_QUANT: res_next.value = qval;
      KIND_ERROR: begin
        res_next.value  = '0;
        res_next.last   = 1'b1;
        res_next.status = STATUS_TRUNC;
      end
      default:    res_next.value = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!stall) begin
      res_valid <= s1_valid;
      res       <= res_next;
    end
  end

endmodule

// File: sv/q8_0_block_dequantizer_bf16.sv
// top level of the q8_0 / bf16 weight stream dequantizer
// usage:
//   s_axis carries one tensor byte per word, s_axis_tlast marks the last byte.
//   m_axis carries one bf16 weight per word; tuser holds the status flag
//   (1 = tensor ended inside a block or pair, value 0, tlast set).
//   cfg writes weights_format (0 bf16 pairs, 1 q8_0 blocks); write only when
//   idle, a write drops any partial block or pair.
// path: the front register loads at the accepting edge, then the queue
//   write, the product stage, and rounding into the output register.
// throughput: one byte per cycle while s_axis_tready is high; set by the single byte input port.
// reset: format returns to q8_0, position to block start, all valids clear.
// stall: when m_axis_tready is low the back end holds, the queue absorbs
//   words in flight and s_axis_tready drops once the queue is full.
module q8_0_block_dequantizer_bf16
  import q8bd_pkg::*;
#(
  parameter int unsigned BLOCK_VALUES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // bf16_value
  output logic        m_axis_tlast,   // last_value
  output logic        m_axis_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic fmt;
  logic cfg_wr;
  logic fj_valid, fj_ready;
  job_t fj;
  logic bj_valid, bj_ready;
  job_t bj;
  res_t res;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_Q8_0;
    end else if (cfg_wr) begin
      fmt <= cfg_data;
    end
  end

  q8bd_front #(.BLOCK_VALUES(BLOCK_VALUES)) u_front (
    .clk(clk), .rst(rst), .fmt(fmt), .cfg_wr(cfg_wr),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .data_byte(s_axis_tdata), .last_byte(s_axis_tlast),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  q8bd_fifo u_fifo (
    .clk(clk), .rst(rst),
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  q8bd_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = res.value;
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = res.status;

`ifndef SYNTHESIS
  // error words always close the tensor
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("error word without tlast");

  // error words carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("error word with nonzero value");

  // stalled output word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
`endif

endmodule

// File: tb/sv/tb.sv
// testbench for the q8_0 / bf16 weight stream dequantizer
module tb;
  import q8bd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NVAL = 32;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  q8_0_block_dequantizer_bf16 #(.BLOCK_VALUES(NVAL)) u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic        fmt;
  logic [5:0]  pos;
  logic [15:0] scale;
  logic [7:0]  low_byte;
  res_t        want_q[$];
  int          errors = 0;
  int          n_words = 0;
  int          n_res = 0;
  int          n_trunc = 0;
  int          send_idle = 0;
  int          recv_stall = 0;

  // exact half * int8 product rounded to bf16
  function automatic logic [15:0] scaled_quant(logic [15:0] h, logic [7:0] q);
    logic        hs, qs, sg;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [8:0]  qm;
    logic [31:0] p, sig, rem, hw;
    int          e, k, sh, ue;
    hs = h[15]; ex = h[14:10]; man = h[9:0];
    qs = q[7];
    qm = qs ? (9'd256 - {1'b0, q}) : {1'b0, q};
    sg = hs ^ qs;
    if (ex == 5'h1f) begin
      if (man != 0) return {hs, 8'hff, 7'(man >> 3)} | 16'h0040;
      if (qm == 0) return 16'h7fc0;
      return {sg, 15'h7f80};
    end
    if (ex == 0) begin
      sig = {22'd0, man}; e = -24;
    end else begin
      sig = {22'd0, 1'b1, man}; e = int'(ex) - 25;
    end
    p = sig * {23'd0, qm};
    if (p == 0) return {sg, 15'd0};
    k = 17;
    while (p[k] == 1'b0) k--;
    if (k <= 7) begin
      sig = p << (7 - k);
    end else begin
      sh = k - 7;
      sig = p >> sh;
      rem = p & ((32'd1 << sh) - 1);
      hw = 32'd1 << (sh - 1);
      if (rem > hw || (rem == hw && sig[0])) sig++;
      if (sig == 256) begin
        sig = 128; k++;
      end
    end
    ue = k + e + 127;
    return {sg, 8'(ue), sig[6:0]};
  endfunction

  // advance predictor by one accepted byte
  task automatic predict_byte(logic [7:0] b, logic lst);
    logic        have, done;
    logic [15:0] v;
    res_t        r;
    have = 0; done = 0; v = '0;
    if (fmt == FMT_Q8_0) begin
      if (pos == 0) begin
        scale = {8'd0, b}; pos = 1;
      end else if (pos == 1) begin
        scale[15:8] = b; pos = 2;
      end else begin
        v = scaled_quant(scale, b); have = 1; pos++;
        if (pos >= NVAL + 2) begin
          pos = 0; done = 1;
        end
      end
    end else begin
      if (pos == 0) begin
        low_byte = b; pos = 1;
      end else begin
        v = {b, low_byte}; have = 1; done = 1; pos = 0;
      end
    end
    if (lst && !done) begin
      pos = 0;
      r = '{value: 16'd0, last: 1'b1, status: STATUS_TRUNC};
      want_q.push_back(r);
      n_trunc++;
    end else if (have) begin
      r = '{value: v, last: lst, status: STATUS_OK};
      want_q.push_back(r);
    end
  endtask

  // idling percentages per phase
  int pct_send = 0;
  int pct_recv = 0;

  // send one word, random sender gaps; valid stays up between back-to-back words
  task automatic push_byte(logic [7:0] b, logic lst);
    while ($urandom_range(99) < pct_send) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk); send_idle++;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_byte(b, lst);
    n_words++;
    @(negedge clk);
  endtask

  // drop valid, wait for drain, then settle past the pipeline
  task automatic drain();
    int t;
    t = 0;
    s_axis_tvalid <= 1'b0;
    while (want_q.size() != 0 && t < 200000) begin
      @(negedge clk); t++;
    end
    repeat (10) @(negedge clk);
  endtask

  task automatic write_format(logic f);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fmt = f; pos = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver ready with random stalls
  always @(negedge clk) begin
    logic rdy;
    if (rst) m_axis_tready <= 1'b0;
    else begin
      rdy = ($urandom_range(99) >= pct_recv);
      m_axis_tready <= rdy;
      if (!rdy) recv_stall++;
    end
  end

  // result checker
  always @(posedge clk) begin
    res_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_res++;
      if (want_q.size() == 0) begin
        $error("unexpected word value=%h last=%b status=%b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        errors++;
      end else begin
        w = want_q.pop_front();
        if (m_axis_tdata !== w.value) begin
          $error("bf16_value expected %h actual %h", w.value, m_axis_tdata); errors++;
        end
        if (m_axis_tlast !== w.last) begin
          $error("last_value expected %b actual %b", w.last, m_axis_tlast); errors++;
        end
        if (m_axis_tuser !== w.status) begin
          $error("status expected %b actual %b", w.status, m_axis_tuser); errors++;
        end
      end
    end
  end

  // directed rows: check flag, byte, last, typed value (checked vs predictor too)
  typedef struct {
    logic        chk;
    logic [7:0]  b;
    logic        lst;
    logic [15:0] val;
  } row_t;

  row_t rows[] = '{
    // inf scale 0x7c00, quants 0, 1, -128
    '{0, 8'h00, 0, 0}, '{0, 8'h7c, 0, 0},
    '{1, 8'h00, 0, 16'h7fc0}, '{1, 8'h01, 0, 16'h7f80}, '{1, 8'h80, 0, 16'hff80},
    // truncated tensor inside the block
    '{1, 8'h7f, 1, 16'h0000},
    // nan scale 0xfe01 then truncation inside the block
    '{0, 8'h01, 0, 0}, '{0, 8'hfe, 0, 0},
    '{0, 8'hff, 0, 0}, '{0, 8'h55, 0, 0},
    '{1, 8'h00, 1, 16'h0000},
    // subnormal scale 0x0001 and negative zero scale
    '{0, 8'h01, 0, 0}, '{0, 8'h00, 0, 0}, '{0, 8'h7f, 0, 0}, '{0, 8'h81, 0, 0},
    '{0, 8'h00, 1, 0},
    '{0, 8'h00, 0, 0}, '{0, 8'h80, 0, 0}, '{0, 8'h00, 0, 0}, '{0, 8'h05, 1, 0}
  };

  int ci;
  logic [15:0] sc;

  initial begin
    fmt = FMT_Q8_0; pos = 0; scale = 0; low_byte = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table after reset in q8_0 mode
    foreach (rows[i]) begin
      push_byte(rows[i].b, rows[i].lst);
      if (rows[i].chk && want_q.size() != 0 &&
          want_q[$].value !== rows[i].val) begin
        $error("table row %0d: bf16_value expected %h actual %h",
               i, rows[i].val, want_q[$].value);
        errors++;
      end
    end
    // one full block with extreme scale
    push_byte(8'hff, 0); push_byte(8'h7b, 0);
    for (int j = 0; j < NVAL; j++) push_byte(j[0] ? 8'h80 : 8'h7f, j == NVAL - 1);

    // random phases across formats and idling profiles
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin pct_send = 0;  pct_recv = 0;  end
        1: begin pct_send = 59; pct_recv = 0;  end
        2: begin pct_send = 0;  pct_recv = 59; end
        default: begin pct_send = 20; pct_recv = 20; end
      endcase
      write_format(ph[0] ? FMT_BF16 : FMT_Q8_0);
      ci = 0;
      while (ci < 150) begin
        if ($urandom_range(9) < 8) begin
          // well-formed tensor of one block / three pairs
          if (fmt == FMT_Q8_0) begin
            sc = 16'($urandom);
            if ($urandom_range(7) == 0) sc[14:10] = $urandom_range(1) ? 5'h1f : 5'h00;
            push_byte(sc[7:0], 0); push_byte(sc[15:8], 0);
            for (int j = 0; j < NVAL; j++) push_byte(8'($urandom), j == NVAL - 1);
            ci += NVAL + 2;
          end else begin
            for (int j = 0; j < 6; j++) push_byte(8'($urandom), j == 5);
            ci += 6;
          end
        end else begin
          // random run of bytes, most often ending the tensor at a random spot
          repeat ($urandom_range(1, 20)) push_byte(8'($urandom), 0);
          push_byte(8'($urandom), $urandom_range(3) != 0);
          ci += 10;
        end
      end
      // format change after stray bytes drops any partial block or pair
      push_byte(8'($urandom), 0);
      push_byte(8'($urandom), 0);
    end
    write_format(FMT_Q8_0);
    drain();

    if (want_q.size() != 0) begin
      $error("%0d results never arrived", want_q.size());
      errors++;
    end
    $display("covered %0d bytes, %0d results (%0d truncations) in both formats",
             n_words, n_res, n_trunc);
    $display("sender idle %0d cycles, receiver stalled %0d cycles", send_idle, recv_stall);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: q8_0_block_dequantizer_bf16.f
sv/q8bd_pkg.sv
sv/q8bd_front.sv
sv/q8bd_fifo.sv
sv/q8bd_back.sv
sv/q8_0_block_dequantizer_bf16.sv
tb/sv/tb.sv
